// ===== sv/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and the control store of the MD5 digest unit.
// ----------------------------------------------------------------------------
package md5_pkg;

	// Sequencer types
	typedef logic [3:0] pc_t;
	typedef logic [3:0] op_t;
	typedef logic [3:0] cond_t;

	// Datapath operations
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_IDLE     = 4'd1;
	localparam op_t OP_PREFETCH = 4'd2;
	localparam op_t OP_ROUND    = 4'd3;
	localparam op_t OP_ADDCHAIN = 4'd4;
	localparam op_t OP_CLRFILL  = 4'd5;
	localparam op_t OP_PAD      = 4'd6;
	localparam op_t OP_ZFILL    = 4'd7;
	localparam op_t OP_LEN      = 4'd8;
	localparam op_t OP_LENH     = 4'd9;
	localparam op_t OP_OUT      = 4'd10;

	// Jump conditions
	localparam cond_t C_NEVER    = 4'd0;
	localparam cond_t C_ALWAYS   = 4'd1;
	localparam cond_t C_GO       = 4'd2;
	localparam cond_t C_FULL     = 4'd3;
	localparam cond_t C_RNDLAST  = 4'd4;
	localparam cond_t C_NOTFIN   = 4'd5;
	localparam cond_t C_LENDONE  = 4'd6;
	localparam cond_t C_PADDONE  = 4'd7;
	localparam cond_t C_ZDONE    = 4'd8;
	localparam cond_t C_BIG      = 4'd9;
	localparam cond_t C_OUTFREE  = 4'd10;

	// Program addresses
	localparam pc_t U_IDLE  = 4'd0;
	localparam pc_t U_DISP  = 4'd1;
	localparam pc_t U_CPRE  = 4'd2;
	localparam pc_t U_CRND  = 4'd3;
	localparam pc_t U_CADD  = 4'd4;
	localparam pc_t U_CAFT  = 4'd5;
	localparam pc_t U_CAFT2 = 4'd6;
	localparam pc_t U_PAD   = 4'd7;
	localparam pc_t U_ZFILL = 4'd8;
	localparam pc_t U_ZEXIT = 4'd9;
	localparam pc_t U_LEN   = 4'd10;
	localparam pc_t U_LENH  = 4'd11;
	localparam pc_t U_OUT   = 4'd12;

	// One control word
	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		pc_t   nxt;
	} uword_t;

	// Status seen by the sequencer
	typedef struct packed {
		logic go;
		logic full;
		logic rnd_last;
		logic notfin;
		logic len_done;
		logic pad_done;
		logic zdone;
		logic big;
		logic out_free;
	} flags_t;

	// Initial chaining words
	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	// Control store
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		case (pc)
			U_IDLE:  w = '{OP_IDLE,     C_GO,      U_DISP,  U_IDLE};
			U_DISP:  w = '{OP_NOP,      C_FULL,    U_CPRE,  U_PAD};
			U_CPRE:  w = '{OP_PREFETCH, C_ALWAYS,  U_CRND,  U_CRND};
			U_CRND:  w = '{OP_ROUND,    C_RNDLAST, U_CADD,  U_CRND};
			U_CADD:  w = '{OP_ADDCHAIN, C_NOTFIN,  U_IDLE,  U_CAFT};
			U_CAFT:  w = '{OP_CLRFILL,  C_LENDONE, U_OUT,   U_CAFT2};
			U_CAFT2: w = '{OP_NOP,      C_PADDONE, U_ZFILL, U_PAD};
			U_PAD:   w = '{OP_PAD,      C_ALWAYS,  U_ZFILL, U_ZFILL};
			U_ZFILL: w = '{OP_ZFILL,    C_ZDONE,   U_ZEXIT, U_ZFILL};
			U_ZEXIT: w = '{OP_NOP,      C_BIG,     U_CPRE,  U_LEN};
			U_LEN:   w = '{OP_LEN,      C_ALWAYS,  U_LENH,  U_LENH};
			U_LENH:  w = '{OP_LENH,     C_ALWAYS,  U_CPRE,  U_CPRE};
			U_OUT:   w = '{OP_OUT,      C_OUTFREE, U_IDLE,  U_OUT};
			default: w = '{OP_NOP,      C_ALWAYS,  U_IDLE,  U_IDLE};
		endcase
		return w;
	endfunction

	// Per-step additive constant
	function automatic logic [31:0] step_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Left-rotate amount per step
	function automatic logic [4:0] rot_amt(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
			4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
			4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
			4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	// Message word used by a step (mod-16 arithmetic)
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] n;
		logic [3:0] g;
		n = i[3:0];
		case (i[5:4])
			2'd0:    g = n;
			2'd1:    g = (n << 2) + n + 4'd1;
			2'd2:    g = (n << 1) + n + 4'd5;
			2'd3:    g = (n << 3) - n;
			default: g = n;
		endcase
		return g;
	endfunction

endpackage

// ===== sv/md5_ram.sv =====
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/md5_seq.sv =====
// ----------------------------------------------------------------------------
// md5_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module md5_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  md5_pkg::flags_t flags,
	output md5_pkg::uword_t ctl,
	output md5_pkg::pc_t    pc
);
	import md5_pkg::*;

	pc_t  pc_q;
	logic taken;

	assign ctl = ucode(pc_q);
	assign pc  = pc_q;

	// Jump condition select
	always_comb begin
		case (ctl.cond)
			C_NEVER:   taken = 1'b0;
			C_ALWAYS:  taken = 1'b1;
			C_GO:      taken = flags.go;
			C_FULL:    taken = flags.full;
			C_RNDLAST: taken = flags.rnd_last;
			C_NOTFIN:  taken = flags.notfin;
			C_LENDONE: taken = flags.len_done;
			C_PADDONE: taken = flags.pad_done;
			C_ZDONE:   taken = flags.zdone;
			C_BIG:     taken = flags.big;
			C_OUTFREE: taken = flags.out_free;
			default:   taken = 1'b0;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= U_IDLE;
		end else begin
			pc_q <= taken ? ctl.target : ctl.nxt;
		end
	end

endmodule

// ===== sv/md5_compress.sv =====
// ----------------------------------------------------------------------------
// md5_compress
// Chaining words, working registers and the one-step-per-cycle MD5 round.
// ----------------------------------------------------------------------------
module md5_compress (
	input  logic          clk,
	input  logic          arst_n,
	input  md5_pkg::op_t  op,
	input  logic          load_init,
	input  logic [31:0]   msg_word,
	output logic [3:0]    msg_addr,
	output logic          rnd_last,
	output logic [127:0]  digest
);
	import md5_pkg::*;

	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] h0_q, h1_q, h2_q, h3_q;
	logic [5:0]  rnd_q;
	logic [5:0]  rnd_nxt;
	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] rot_dbl;
	logic [31:0] new_b;

	assign rnd_nxt  = rnd_q + 6'd1;
	assign rnd_last = (rnd_q == 6'd63);
	assign msg_addr = (op == OP_PREFETCH) ? 4'd0 : msg_index(rnd_nxt);
	assign digest   = {h3_q, h2_q, h1_q, h0_q};

	// Round function and step update
	always_comb begin
		case (rnd_q[5:4])
			2'd0:    f = d_q ^ (b_q & (c_q ^ d_q));
			2'd1:    f = c_q ^ (d_q & (b_q ^ c_q));
			2'd2:    f = b_q ^ c_q ^ d_q;
			2'd3:    f = c_q ^ (b_q | ~d_q);
			default: f = b_q;
		endcase
		sum     = a_q + f + step_const(rnd_q) + msg_word;
		rot_dbl = {sum, sum} << rot_amt(rnd_q);
		new_b   = b_q + rot_dbl[63:32];
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (op == OP_PREFETCH) begin
			a_q <= h0_q;
			b_q <= h1_q;
			c_q <= h2_q;
			d_q <= h3_q;
		end else if (op == OP_ROUND) begin
			a_q <= d_q;
			b_q <= new_b;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	// Step counter and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			h0_q  <= INIT_A;
			h1_q  <= INIT_B;
			h2_q  <= INIT_C;
			h3_q  <= INIT_D;
		end else begin
			if (op == OP_PREFETCH) begin
				rnd_q <= '0;
			end else if (op == OP_ROUND) begin
				rnd_q <= rnd_nxt;
			end
			if (load_init) begin
				h0_q <= INIT_A;
				h1_q <= INIT_B;
				h2_q <= INIT_C;
				h3_q <= INIT_D;
			end else if (op == OP_ADDCHAIN) begin
				h0_q <= h0_q + a_q;
				h1_q <= h1_q + b_q;
				h2_q <= h2_q + c_q;
				h3_q <= h3_q + d_q;
			end
		end
	end

endmodule

// ===== sv/md5_message_digest_unit.sv =====
// Throughput: one word per cycle while idle; a byte that fills a 64-byte block
// holds off input through dispatch, prefetch, the rounds and the chaining add.
// At end of message, padding, the length words and a second block if needed
// precede the digest; a digest still held on the output stalls the next one.
// Reset: chaining words to the initial values, bit count to zero, sequencer
// to idle, output empty; the block RAM is not cleared.
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// Byte-stream MD5 digest unit driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
module md5_message_digest_unit (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]   s_axis_tuser,  // [0] has_byte
	input  logic         s_axis_tlast,  // end_of_message
	// output stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // [63:0] digest_low, [127:64] digest_high
);
	import md5_pkg::*;

	uword_t       ctl;
	pc_t          pc;
	flags_t       flags;

	logic         acc;
	logic         full_now;
	logic [5:0]   pos;
	logic [1:0]   lane;
	logic [63:0]  count_q;
	logic [23:0]  wbuf_q;
	logic [4:0]   widx_q;
	logic         fin_q, full_q, pad_done_q, len_done_q, big_q;
	logic         zdone;
	logic         out_free;
	logic         load_init;
	logic [127:0] digest;
	logic [127:0] out_q;
	logic         out_valid_q;

	logic         ram_we;
	logic [3:0]   ram_waddr;
	logic [31:0]  ram_wdata;
	logic [3:0]   ram_raddr;
	logic [31:0]  ram_rdata;
	logic [31:0]  pad_word;
	logic         rnd_last;

	assign pos      = count_q[8:3];
	assign lane     = pos[1:0];
	assign s_axis_tready = (ctl.op == OP_IDLE);
	assign acc      = s_axis_tvalid && s_axis_tready;
	assign full_now = s_axis_tuser[0] && (pos == 6'd63);
	assign zdone    = (widx_q == 5'd16) || ((widx_q == 5'd14) && !big_q);
	assign out_free = !out_valid_q || m_axis_tready;
	assign load_init = (ctl.op == OP_OUT) && out_free;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Sequencer status
	always_comb begin
		flags.go       = acc && (full_now || s_axis_tlast);
		flags.full     = full_q;
		flags.rnd_last = rnd_last;
		flags.notfin   = !fin_q;
		flags.len_done = len_done_q;
		flags.pad_done = pad_done_q;
		flags.zdone    = zdone;
		flags.big      = big_q;
		flags.out_free = out_free;
	end

	// Pad word: pending bytes, then 0x80, then zeros
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (k < 3 && k < int'(lane)) begin
				pad_word[8*k +: 8] = wbuf_q[8*k +: 8];
			end else if (k == int'(lane)) begin
				pad_word[8*k +: 8] = PAD_BYTE;
			end else begin
				pad_word[8*k +: 8] = 8'h00;
			end
		end
	end

	// Block RAM write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos[5:2];
		ram_wdata = {s_axis_tdata, wbuf_q};
		case (ctl.op)
			OP_IDLE: begin
				ram_we = acc && s_axis_tuser[0] && (lane == 2'd3);
			end
			OP_PAD: begin
				ram_we    = 1'b1;
				ram_wdata = pad_word;
			end
			OP_ZFILL: begin
				ram_we    = !zdone;
				ram_waddr = widx_q[3:0];
				ram_wdata = '0;
			end
			OP_LEN: begin
				ram_we    = 1'b1;
				ram_waddr = 4'd14;
				ram_wdata = count_q[31:0];
			end
			OP_LENH: begin
				ram_we    = 1'b1;
				ram_waddr = 4'd15;
				ram_wdata = count_q[63:32];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Partial word buffer
	always_ff @(posedge clk) begin
		if (acc && s_axis_tuser[0]) begin
			case (lane)
				2'd0:    wbuf_q[7:0]   <= s_axis_tdata;
				2'd1:    wbuf_q[15:8]  <= s_axis_tdata;
				2'd2:    wbuf_q[23:16] <= s_axis_tdata;
				default: wbuf_q        <= wbuf_q;
			endcase
		end
	end

	// Bit count, finalization flags and fill index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			fin_q      <= 1'b0;
			full_q     <= 1'b0;
			pad_done_q <= 1'b0;
			len_done_q <= 1'b0;
			big_q      <= 1'b0;
			widx_q     <= '0;
		end else begin
			case (ctl.op)
				OP_IDLE: begin
					if (acc) begin
						if (s_axis_tuser[0]) begin
							count_q <= count_q + 64'd8;
						end
						fin_q  <= s_axis_tlast;
						full_q <= full_now;
					end
				end
				OP_CLRFILL: begin
					widx_q <= '0;
					big_q  <= 1'b0;
				end
				OP_PAD: begin
					widx_q     <= {1'b0, pos[5:2]} + 5'd1;
					big_q      <= (pos[5:3] == 3'b111);
					pad_done_q <= 1'b1;
				end
				OP_ZFILL: begin
					if (!zdone) begin
						widx_q <= widx_q + 5'd1;
					end
				end
				OP_LENH: begin
					len_done_q <= 1'b1;
				end
				OP_OUT: begin
					if (out_free) begin
						count_q    <= '0;
						fin_q      <= 1'b0;
						full_q     <= 1'b0;
						pad_done_q <= 1'b0;
						len_done_q <= 1'b0;
						big_q      <= 1'b0;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_init) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_init) begin
			out_q <= digest;
		end
	end

	md5_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl),
		.pc     (pc)
	);

	md5_ram #(
		.WIDTH (32),
		.DEPTH (16)
	) u_block_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	md5_compress u_compress (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (ctl.op),
		.load_init (load_init),
		.msg_word  (ram_rdata),
		.msg_addr  (ram_raddr),
		.rnd_last  (rnd_last),
		.digest    (digest)
	);

	// The block RAM is never written while the round unit reads it
	a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_ROUND) |-> !ram_we)
		else $error("block RAM written during compression");

	// Length words always land after the fill stops at word 14
	a_len_after_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(pc == U_LEN) |-> (widx_q == 5'd14))
		else $error("length written at wrong fill position");

	// A new digest leaves the unit with the count cleared
	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> (count_q == 64'd0) && !fin_q)
		else $error("message state not cleared after digest");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MD5 digest unit. Message words stream in with
// random gaps on the input side and random back-pressure on the digest side.
// A behavioral MD5 predictor computes each digest when the closing word is
// accepted, and every digest the unit returns is checked against it in order.
// ----------------------------------------------------------------------------
module testbench;

	import md5_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned CALM_FROM   = 1500;
	localparam int unsigned CALM_TO     = 4500;
	localparam int unsigned IDLE_PCT    = 23;
	localparam int          ROT_TBL [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
		4, 11, 16, 23, 6, 10, 15, 21};

	// One input word as queued for the driver
	typedef struct {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
		bit         drain;    // hold off until all digests are back
	} msg_word_t;

	typedef struct {
		logic [63:0] low;
		logic [63:0] high;
	} digest_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata;   // [7:0] data_byte
	logic [0:0]   s_axis_tuser;   // [0] has_byte
	logic         s_axis_tlast;   // end_of_message
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;   // [63:0] digest_low, [127:64] digest_high

	md5_message_digest_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	msg_word_t   pending_words [$];
	digest_t     digest_expected [$];
	msg_word_t   word_on_bus;
	digest_t     digest_next;
	digest_t     digest_want;
	int unsigned digests_predicted;
	int unsigned digests_seen;
	int unsigned cycle_count = 0;
	int unsigned error_count = 0;

	// Predictor state
	logic [31:0] chain_q [4];
	logic [7:0]  block_q [64];
	logic [63:0] bit_total;
	logic [31:0] sine_k [64];

	// Clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void note_error(input string msg);
		if (error_count < 10)
			$display("mismatch: %s", msg);
		error_count++;
	endfunction

	function automatic bit idle_roll();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic void load_chain_init();
		chain_q[0] = INIT_A;
		chain_q[1] = INIT_B;
		chain_q[2] = INIT_C;
		chain_q[3] = INIT_D;
		bit_total  = '0;
	endfunction

	// 64-step transform of block_q into the chaining words
	function automatic void md5_compress();
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f, t;
		int          g, r;
		for (int i = 0; i < 16; i++)
			m[i] = {block_q[4*i+3], block_q[4*i+2], block_q[4*i+1], block_q[4*i]};
		a = chain_q[0];
		b = chain_q[1];
		c = chain_q[2];
		d = chain_q[3];
		for (int i = 0; i < 64; i++) begin
			r = i / 16;
			case (r)
				0: begin
					f = d ^ (b & (c ^ d));
					g = i;
				end
				1: begin
					f = c ^ (d & (b ^ c));
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			t = d;
			d = c;
			c = b;
			b = b + rotl32(a + f + sine_k[i] + m[g], ROT_TBL[4 * r + i % 4]);
			a = t;
		end
		chain_q[0] += a;
		chain_q[1] += b;
		chain_q[2] += c;
		chain_q[3] += d;
	endfunction

	// Take one word; returns 1 and the digest when it closes a message
	function automatic bit md5_absorb(input msg_word_t w, output digest_t dg);
		int pos;
		if (w.has_byte) begin
			pos = int'(bit_total[8:3]);
			block_q[pos] = w.data;
			bit_total += 64'd8;
			if (pos == 63)
				md5_compress();
		end
		if (!w.eom)
			return 1'b0;
		// pad, spill into a second block when the length won't fit
		pos = int'(bit_total[8:3]);
		block_q[pos] = PAD_BYTE;
		for (int i = pos + 1; i < 64; i++)
			block_q[i] = 8'h00;
		if (pos >= 56) begin
			md5_compress();
			for (int i = 0; i < 56; i++)
				block_q[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++)
			block_q[56+i] = bit_total[8*i +: 8];
		md5_compress();
		dg.low  = {chain_q[1], chain_q[0]};
		dg.high = {chain_q[3], chain_q[2]};
		load_chain_init();
		return 1'b1;
	endfunction

	function automatic void push_word(input logic [7:0] data, input logic has_byte,
			input logic eom, input bit drain);
		msg_word_t w;
		w.data     = data;
		w.has_byte = has_byte;
		w.eom      = eom;
		w.drain    = drain;
		pending_words.push_back(w);
	endfunction

	// Input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid     <= 1'b0;
			s_axis_tdata      <= '0;
			s_axis_tuser      <= '0;
			s_axis_tlast      <= 1'b0;
			digests_predicted = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (md5_absorb(word_on_bus, digest_next)) begin
					digest_expected.push_back(digest_next);
					digests_predicted++;
				end
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_words.size() != 0 && !idle_roll() &&
						!(pending_words[0].drain && digests_predicted != digests_seen)) begin
					word_on_bus = pending_words.pop_front();
					s_axis_tdata  <= word_on_bus.data;
					s_axis_tuser  <= word_on_bus.has_byte;
					s_axis_tlast  <= word_on_bus.eom;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Digest monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			digests_seen  <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				digests_seen <= digests_seen + 1;
				if (digest_expected.size() == 0) begin
					note_error($sformatf("unexpected digest %h", m_axis_tdata));
				end else begin
					digest_want = digest_expected.pop_front();
					if (m_axis_tdata[63:0] !== digest_want.low)
						note_error($sformatf("digest_low expected %h got %h",
							digest_want.low, m_axis_tdata[63:0]));
					if (m_axis_tdata[127:64] !== digest_want.high)
						note_error($sformatf("digest_high expected %h got %h",
							digest_want.high, m_axis_tdata[127:64]));
				end
			end
			m_axis_tready <= !idle_roll();
		end
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		real         r;
		int unsigned msgs, len, roll;
		bit          close_on_byte;

		arst_n      = 1'b0;

		// step constants from |sin(i+1)|
		for (int i = 0; i < 64; i++) begin
			r = $sin(real'(i + 1));
			if (r < 0.0)
				r = -r;
			sine_k[i] = 32'(longint'($floor(r * 4294967296.0)));
		end
		for (int i = 0; i < 64; i++)
			block_q[i] = 8'h00;
		load_chain_init();

		// directed: empty message, byte with end, byte then lone end, gaps
		push_word(8'hA5, 1'b0, 1'b1, 1'b0);
		push_word(8'h00, 1'b1, 1'b1, 1'b0);
		push_word(8'hFF, 1'b1, 1'b1, 1'b0);
		push_word(8'hFF, 1'b0, 1'b0, 1'b0);
		push_word(8'h61, 1'b1, 1'b0, 1'b0);
		push_word(8'h00, 1'b0, 1'b0, 1'b0);
		push_word(8'h62, 1'b1, 1'b0, 1'b0);
		push_word(8'h63, 1'b1, 1'b1, 1'b0);
		push_word(8'h5A, 1'b1, 1'b0, 1'b0);
		push_word(8'hFF, 1'b0, 1'b1, 1'b0);
		push_word(8'h00, 1'b0, 1'b1, 1'b0);
		push_word(8'hFF, 1'b0, 1'b1, 1'b0);
		push_word(8'h80, 1'b1, 1'b0, 1'b0);
		push_word(8'h7F, 1'b1, 1'b1, 1'b0);

		// random messages, lengths clustered around the padding boundaries
		msgs = 0;
		while (pending_words.size() < 600) begin
			roll = $urandom_range(0, 99);
			if (roll < 55)
				len = $urandom_range(0, 8);
			else if (roll < 80)
				len = $urandom_range(50, 72);
			else if (roll < 88)
				len = $urandom_range(110, 136);
			else
				len = $urandom_range(0, 64);
			close_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
			for (int unsigned k = 0; k < len; k++) begin
				if ($urandom_range(0, 99) < 8)
					push_word(8'($urandom), 1'b0, 1'b0, 1'b0);
				push_word(8'($urandom), 1'b1, close_on_byte && (k == len - 1),
					(k == 0) && (msgs == 0 || msgs == 18));
			end
			if (!close_on_byte)
				push_word(8'($urandom), 1'b0, 1'b1, len == 0 && msgs == 0);
			msgs++;
		end

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_words.size() != 0 || s_axis_tvalid || digest_expected.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
		if (digest_expected.size() != 0)
			note_error($sformatf("%0d digests never arrived", digest_expected.size()));

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
